FILE: sv/tem_pkg.sv
// Shared types, constants and helpers for the text extent measuring block.
package tem_pkg;

	// Table geometry and fixed-point format
	localparam int MAX_GLYPHS = 256;
	localparam int FRAC_BITS  = 4;
	localparam int IDX_W      = $clog2(MAX_GLYPHS);
	localparam int CNT_W      = $clog2(MAX_GLYPHS + 1);

	// Extent width, working sum width and saturation limits
	localparam int EXT_W = 23;
	localparam int SUM_W = EXT_W + 2;
	localparam logic [EXT_W-1:0]        EXT_MAX   = {EXT_W{1'b1}};
	localparam logic signed [SUM_W-1:0] EXT_MAX_S = SUM_W'(EXT_MAX);
	localparam logic signed [SUM_W-1:0] EXT_MIN_S = -EXT_MAX_S;

	// Configuration port
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_SPACING    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_COUNT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_INDEX   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_ENABLED = 2'd3;

	// Item functions
	localparam logic FUNC_LOAD    = 1'b0;
	localparam logic FUNC_MEASURE = 1'b1;

	// Character codes with special meaning
	localparam logic [15:0] CHAR_TAB   = 16'h0009;
	localparam logic [15:0] CHAR_LF    = 16'h000A;
	localparam logic [15:0] CHAR_CR    = 16'h000D;
	localparam logic [15:0] CHAR_SPACE = 16'h0020;

	// One glyph table entry
	typedef struct packed {
		logic [15:0]        chr;
		logic signed [15:0] offset_x;
		logic signed [15:0] offset_y;
		logic [11:0]        glyph_width;
		logic [11:0]        glyph_height;
		logic signed [15:0] advance_x;
	} glyph_entry_t;

	// Result of a glyph lookup
	typedef struct packed {
		logic done;
		logic found;
	} search_res_t;

	// Command to the pen update unit
	typedef struct packed {
		logic         start;
		logic         newline;
		logic         draw;
		glyph_entry_t glyph;
	} pen_cmd_t;

	// Status of the pen update unit
	typedef struct packed {
		logic busy;
		logic done;
	} pen_stat_t;

	// Whitespace codes: tab to carriage return, and space
	function automatic logic is_space(input logic [15:0] c);
		return c inside {[CHAR_TAB:CHAR_CR], CHAR_SPACE};
	endfunction

endpackage

FILE: sv/tem_table.sv
// Glyph table memory: one write port, one registered read port.
module tem_table (
	input  logic                        clk,
	input  logic                        we,
	input  logic [tem_pkg::IDX_W-1:0]   waddr,
	input  tem_pkg::glyph_entry_t       wdata,
	input  logic [tem_pkg::IDX_W-1:0]   raddr,
	output tem_pkg::glyph_entry_t       rdata_q
);

	tem_pkg::glyph_entry_t mem [tem_pkg::MAX_GLYPHS];

	// Write on load, read every cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

endmodule

FILE: sv/tem_search.sv
// Lower-bound binary search over the glyph table, with default fallback.
module tem_search (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [15:0]                 chr,
	input  logic [8:0]                  glyph_count,
	input  logic [7:0]                  default_index,
	input  logic                        default_enabled,
	output logic [tem_pkg::IDX_W-1:0]   raddr,
	input  tem_pkg::glyph_entry_t       rdata,
	output tem_pkg::search_res_t        res,
	output tem_pkg::glyph_entry_t       entry
);

	localparam logic [2:0] SR_IDLE  = 3'd0;
	localparam logic [2:0] SR_PROBE = 3'd1;
	localparam logic [2:0] SR_CHECK = 3'd2;
	localparam logic [2:0] SR_DEF   = 3'd3;
	localparam logic [2:0] SR_FIN   = 3'd4;

	logic [2:0]                  state_q, state_nx;
	logic [tem_pkg::CNT_W-1:0]   lo_q, hi_q, n_q, n_start, lo_nx, hi_nx;
	logic [tem_pkg::CNT_W:0]     mid_sum;
	logic [tem_pkg::IDX_W-1:0]   mid_q, mid_nx;
	logic [15:0]                 chr_q;
	logic                        found_q, take_entry, def_ok;
	tem_pkg::glyph_entry_t       entry_q;

	// Clip the count, qualify the default, narrow the interval
	always_comb begin
		n_start = (32'(glyph_count) > tem_pkg::MAX_GLYPHS) ?
			tem_pkg::CNT_W'(tem_pkg::MAX_GLYPHS) : tem_pkg::CNT_W'(glyph_count);
		def_ok  = default_enabled && (32'(default_index) < tem_pkg::MAX_GLYPHS);
		if (rdata.chr < chr_q) begin
			lo_nx = tem_pkg::CNT_W'(mid_q) + tem_pkg::CNT_W'(1);
			hi_nx = hi_q;
		end else begin
			lo_nx = lo_q;
			hi_nx = tem_pkg::CNT_W'(mid_q);
		end
		mid_sum = {1'b0, lo_nx} + {1'b0, hi_nx};
		mid_nx  = tem_pkg::IDX_W'(mid_sum >> 1);
	end

	// Sequence the probes and pick the next read address
	always_comb begin
		state_nx   = state_q;
		raddr      = mid_q;
		take_entry = 1'b0;
		case (state_q)
			SR_IDLE: begin
				if (start) begin
					if (n_start != '0) begin
						raddr    = tem_pkg::IDX_W'(n_start >> 1);
						state_nx = SR_PROBE;
					end else if (def_ok) begin
						raddr    = tem_pkg::IDX_W'(default_index);
						state_nx = SR_DEF;
					end else begin
						state_nx = SR_FIN;
					end
				end
			end
			SR_PROBE: begin
				if (lo_nx < hi_nx) begin
					raddr = mid_nx;
				end else if (lo_nx < n_q) begin
					raddr    = tem_pkg::IDX_W'(lo_nx);
					state_nx = SR_CHECK;
				end else if (def_ok) begin
					raddr    = tem_pkg::IDX_W'(default_index);
					state_nx = SR_DEF;
				end else begin
					state_nx = SR_FIN;
				end
			end
			SR_CHECK: begin
				if (rdata.chr == chr_q) begin
					take_entry = 1'b1;
					state_nx   = SR_FIN;
				end else if (def_ok) begin
					raddr    = tem_pkg::IDX_W'(default_index);
					state_nx = SR_DEF;
				end else begin
					state_nx = SR_FIN;
				end
			end
			SR_DEF: begin
				take_entry = 1'b1;
				state_nx   = SR_FIN;
			end
			SR_FIN: begin
				state_nx = SR_IDLE;
			end
			default: begin
				state_nx = SR_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SR_IDLE;
			found_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == SR_IDLE && start) begin
				found_q <= 1'b0;
			end else if (take_entry) begin
				found_q <= 1'b1;
			end
		end
	end

	// Search interval and captured entry
	always_ff @(posedge clk) begin
		if (state_q == SR_IDLE && start) begin
			lo_q  <= '0;
			hi_q  <= n_start;
			n_q   <= n_start;
			mid_q <= tem_pkg::IDX_W'(n_start >> 1);
			chr_q <= chr;
		end else if (state_q == SR_PROBE) begin
			lo_q  <= lo_nx;
			hi_q  <= hi_nx;
			mid_q <= mid_nx;
		end
		if (take_entry) begin
			entry_q <= rdata;
		end
	end

	assign res.done  = (state_q == SR_FIN);
	assign res.found = found_q;
	assign entry     = entry_q;

endmodule

FILE: sv/tem_pen.sv
// Pen and extent update: one shared saturating adder stepped by a small sequencer.
module tem_pen (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tem_pkg::pen_cmd_t           cmd,
	input  logic                        clear,
	input  logic [15:0]                 line_spacing,
	output tem_pkg::pen_stat_t          stat,
	output logic [tem_pkg::EXT_W-1:0]   max_x,
	output logic [tem_pkg::EXT_W-1:0]   max_y
);

	localparam logic [2:0] PS_IDLE = 3'd0;
	localparam logic [2:0] PS_X0   = 3'd1;
	localparam logic [2:0] PS_WIDE = 3'd2;
	localparam logic [2:0] PS_TALL = 3'd3;
	localparam logic [2:0] PS_HIGH = 3'd4;
	localparam logic [2:0] PS_ADV  = 3'd5;
	localparam logic [2:0] PS_LF   = 3'd6;
	localparam logic [2:0] PS_FIN  = 3'd7;

	localparam int W = tem_pkg::SUM_W;

	logic [2:0]                        step_q;
	logic signed [tem_pkg::EXT_W:0]    pen_x_q;
	logic [tem_pkg::EXT_W-1:0]         pen_y_q, max_x_q, max_y_q, x_q;
	logic signed [W-1:0]               t_q, tall_q;
	tem_pkg::glyph_entry_t             glyph_q;
	logic                              draw_q;

	logic signed [W-1:0]               wf, hf, ls_s, op_a, op_b, sum, pen_x_nx;
	logic [tem_pkg::EXT_W-1:0]         sum_top;

	// Select operands for the current step and saturate the sum
	always_comb begin
		wf   = $signed(W'(glyph_q.glyph_width) << tem_pkg::FRAC_BITS);
		hf   = $signed(W'(glyph_q.glyph_height) << tem_pkg::FRAC_BITS);
		ls_s = $signed(W'(line_spacing));
		case (step_q)
			PS_X0: begin
				op_a = {{(W-tem_pkg::EXT_W-1){pen_x_q[tem_pkg::EXT_W]}}, pen_x_q};
				op_b = {{(W-16){glyph_q.offset_x[15]}}, glyph_q.offset_x};
			end
			PS_WIDE: begin
				op_a = $signed(W'(x_q));
				op_b = wf;
			end
			PS_TALL: begin
				op_a = hf;
				op_b = {{(W-16){glyph_q.offset_y[15]}}, glyph_q.offset_y};
			end
			PS_HIGH: begin
				op_a = $signed(W'(pen_y_q));
				op_b = tall_q;
			end
			PS_ADV: begin
				op_a = t_q;
				op_b = {{(W-16){glyph_q.advance_x[15]}}, glyph_q.advance_x};
			end
			PS_LF: begin
				op_a = $signed(W'(pen_y_q));
				op_b = ls_s;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
		sum     = op_a + op_b;
		sum_top = (sum > tem_pkg::EXT_MAX_S) ? tem_pkg::EXT_MAX : tem_pkg::EXT_W'(sum);
		if (sum > tem_pkg::EXT_MAX_S) begin
			pen_x_nx = tem_pkg::EXT_MAX_S;
		end else if (sum < tem_pkg::EXT_MIN_S) begin
			pen_x_nx = tem_pkg::EXT_MIN_S;
		end else begin
			pen_x_nx = sum;
		end
	end

	// Sequencer, pen position and running extent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= PS_IDLE;
			pen_x_q <= '0;
			pen_y_q <= '0;
			max_x_q <= '0;
			max_y_q <= '0;
		end else if (clear) begin
			pen_x_q <= '0;
			pen_y_q <= '0;
			max_x_q <= '0;
			max_y_q <= '0;
		end else begin
			case (step_q)
				PS_IDLE: begin
					if (cmd.start) begin
						step_q <= cmd.newline ? PS_LF : PS_X0;
					end
				end
				PS_X0: begin
					step_q <= PS_WIDE;
				end
				PS_WIDE: begin
					if (draw_q && sum_top > max_x_q) begin
						max_x_q <= sum_top;
					end
					step_q <= PS_TALL;
				end
				PS_TALL: begin
					step_q <= PS_HIGH;
				end
				PS_HIGH: begin
					if (draw_q && sum_top > max_y_q) begin
						max_y_q <= sum_top;
					end
					step_q <= PS_ADV;
				end
				PS_ADV: begin
					pen_x_q <= pen_x_nx[tem_pkg::EXT_W:0];
					step_q  <= PS_FIN;
				end
				PS_LF: begin
					pen_x_q <= '0;
					pen_y_q <= sum_top;
					step_q  <= PS_FIN;
				end
				PS_FIN: begin
					step_q <= PS_IDLE;
				end
				default: begin
					step_q <= PS_IDLE;
				end
			endcase
		end
	end

	// Intermediate values between steps
	always_ff @(posedge clk) begin
		if (step_q == PS_IDLE && cmd.start) begin
			glyph_q <= cmd.glyph;
			draw_q  <= cmd.draw;
		end
		if (step_q == PS_X0) begin
			x_q <= (sum < 0) ? '0 : sum_top;
		end
		if (step_q == PS_WIDE) begin
			t_q <= sum;
		end
		if (step_q == PS_TALL) begin
			tall_q <= (sum < ls_s) ? ls_s : sum;
		end
	end

	assign stat.busy = (step_q != PS_IDLE);
	assign stat.done = (step_q == PS_FIN);
	assign max_x     = max_x_q;
	assign max_y     = max_y_q;

endmodule

FILE: sv/text_extent_measure.sv
// Top level of the text extent measuring block: handshakes, sequencing and registers.
//
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_ready   func, entry_index, char_code, offset_x, offset_y,
//                                            glyph_width, glyph_height, advance_x, last_char
//  out      source     out_valid / out_ready extent_x, extent_y, status, run_done
//  cfg      sink       cfg_we                cfg_index, cfg_data
//
// A measured character other than a newline or carriage return takes p table probes on one read
// port (at most ceil(log2(n + 1)), n the clipped glyph count); a character drawn from the table
// then also takes five steps of the pen unit's shared adder. The result shows as in_ready returns.
// Reset clears the pen, the extent, the registers and the control state; the table is not cleared.
// A result waits in the output register while out_ready is low; the next item is taken meanwhile.
module text_extent_measure (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            func,
	input  logic [7:0]                      entry_index,
	input  logic [15:0]                     char_code,
	input  logic signed [15:0]              offset_x,
	input  logic signed [15:0]              offset_y,
	input  logic [11:0]                     glyph_width,
	input  logic [11:0]                     glyph_height,
	input  logic signed [15:0]              advance_x,
	input  logic                            last_char,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [tem_pkg::EXT_W-1:0]       extent_x,
	output logic [tem_pkg::EXT_W-1:0]       extent_y,
	output logic                            status,
	output logic                            run_done,
	input  logic                            cfg_we,
	input  logic [tem_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tem_pkg::CFG_W-1:0]       cfg_data
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_PEN    = 2'd2;
	localparam logic [1:0] ST_DONE   = 2'd3;

	logic [1:0]                      state_q;
	logic                            func_q, last_q, status_q;
	logic [15:0]                     chr_q;
	logic [15:0]                     line_spacing_q;
	logic [8:0]                      glyph_count_q;
	logic [7:0]                      default_index_q;
	logic                            default_enabled_q;
	logic                            out_valid_q, status_out_q, run_done_q;
	logic [tem_pkg::EXT_W-1:0]       extent_x_q, extent_y_q;

	logic                            accept, measure, out_free, pen_clear;
	logic                            srch_start, tbl_we;
	logic [tem_pkg::IDX_W-1:0]       tbl_raddr;
	tem_pkg::glyph_entry_t           tbl_wdata, tbl_rdata, srch_entry;
	tem_pkg::search_res_t            srch_res;
	tem_pkg::pen_cmd_t               pen_cmd;
	tem_pkg::pen_stat_t              pen_stat;
	logic [tem_pkg::EXT_W-1:0]       max_x, max_y;

	// Handshake and item decode
	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign measure    = (func == tem_pkg::FUNC_MEASURE);
	assign srch_start = accept && measure && char_code != tem_pkg::CHAR_CR &&
		char_code != tem_pkg::CHAR_LF;
	assign tbl_we     = accept && func == tem_pkg::FUNC_LOAD &&
		(32'(entry_index) < tem_pkg::MAX_GLYPHS);
	assign out_free   = !out_valid_q || out_ready;
	assign pen_clear  = (state_q == ST_DONE) && out_free &&
		func_q == tem_pkg::FUNC_MEASURE && last_q;

	// Pack a load item into a table entry
	always_comb begin
		tbl_wdata.chr          = char_code;
		tbl_wdata.offset_x     = offset_x;
		tbl_wdata.offset_y     = offset_y;
		tbl_wdata.glyph_width  = glyph_width;
		tbl_wdata.glyph_height = glyph_height;
		tbl_wdata.advance_x    = advance_x;
	end

	// Start the pen on a newline or on a found glyph
	always_comb begin
		pen_cmd.start   = (accept && measure && char_code == tem_pkg::CHAR_LF) ||
			(srch_res.done && srch_res.found);
		pen_cmd.newline = (state_q == ST_IDLE);
		pen_cmd.draw    = !tem_pkg::is_space(chr_q) || srch_entry.glyph_width > 12'd1 ||
			srch_entry.glyph_height > 12'd1;
		pen_cmd.glyph   = srch_entry;
	end

	tem_table u_table (
		.clk     (clk),
		.we      (tbl_we),
		.waddr   (tem_pkg::IDX_W'(entry_index)),
		.wdata   (tbl_wdata),
		.raddr   (tbl_raddr),
		.rdata_q (tbl_rdata)
	);

	tem_search u_search (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (srch_start),
		.chr             (char_code),
		.glyph_count     (glyph_count_q),
		.default_index   (default_index_q),
		.default_enabled (default_enabled_q),
		.raddr           (tbl_raddr),
		.rdata           (tbl_rdata),
		.res             (srch_res),
		.entry           (srch_entry)
	);

	tem_pen u_pen (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (pen_cmd),
		.clear        (pen_clear),
		.line_spacing (line_spacing_q),
		.stat         (pen_stat),
		.max_x        (max_x),
		.max_y        (max_y)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_spacing_q    <= '0;
			glyph_count_q     <= '0;
			default_index_q   <= '0;
			default_enabled_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				tem_pkg::REG_LINE_SPACING:    line_spacing_q    <= cfg_data;
				tem_pkg::REG_GLYPH_COUNT:     glyph_count_q     <= cfg_data[8:0];
				tem_pkg::REG_DEFAULT_INDEX:   default_index_q   <= cfg_data[7:0];
				tem_pkg::REG_DEFAULT_ENABLED: default_enabled_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Item sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			status_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						status_q <= 1'b0;
						if (!measure || char_code == tem_pkg::CHAR_CR) begin
							state_q <= ST_DONE;
						end else if (char_code == tem_pkg::CHAR_LF) begin
							state_q <= ST_PEN;
						end else begin
							state_q <= ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					if (srch_res.done) begin
						if (srch_res.found) begin
							state_q <= ST_PEN;
						end else begin
							status_q <= 1'b1;
							state_q  <= ST_DONE;
						end
					end
				end
				ST_PEN: begin
					if (pen_stat.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the fields of the item in work
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			chr_q  <= char_code;
			last_q <= last_char;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			extent_x_q   <= max_x;
			extent_y_q   <= max_y;
			status_out_q <= status_q;
			run_done_q   <= (func_q == tem_pkg::FUNC_MEASURE) && last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign extent_x  = extent_x_q;
	assign extent_y  = extent_y_q;
	assign status    = status_out_q;
	assign run_done  = run_done_q;

	// Checks
	a_ready_drops: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready still high after an item was taken");

	a_done_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(srch_res.done && pen_stat.done))
		else $error("search and pen unit finished together");

	a_pen_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pen_cmd.start |-> !pen_stat.busy)
		else $error("pen unit started while busy");

	a_search_state: assert property (@(posedge clk) disable iff (!arst_n)
		srch_res.done |-> state_q == ST_SEARCH)
		else $error("search finished outside the search state");

endmodule
